[sv/rrq_pkg.sv]
// Package for the retransmission queue: operation codes, register indexes,
// field widths, reset values and the sequencer state type. No dependencies.
`default_nettype none
package rrq_pkg;

  localparam int SEQ_W   = 32;
  localparam int TIME_W  = 32;
  localparam int INT_W   = 16;
  localparam int ATT_W   = 5;
  localparam int PEND_W  = 5;
  localparam int OP_W    = 2;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  // register select is address bit 2
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_MAX_ATT  = 1'b1;

  localparam logic [INT_W-1:0] INTERVAL_RST = 16'd120;
  localparam logic [ATT_W-1:0] MAX_ATT_RST  = 5'd25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WPRIME,
    ST_WALK,
    ST_EPRIME,
    ST_EMIT,
    ST_NULL
  } state_t;

endpackage
`default_nettype wire

[sv/reliable_retransmit_queue_unit.sv]
// Retransmission queue with cumulative acknowledgement, single module.
// Depends on rrq_pkg for codes, widths and the sequencer state type.
//
// Input transactions arrive on s_*: s_tuser carries the operation (enqueue,
// ack, tick, clear), s_tdata the sequence and current time. Results leave on
// m_*: m_tuser flags resend/overflow, m_tdata carries sequence, attempt count
// and pending count; m_tlast marks the final result of one input transaction.
// Enqueue, ack and clear give one result, loaded into the output register on
// the accepting edge (valid from the next cycle); the block is idle again at once.
// A tick with N entries held occupies the block, plus output stalls, for these
// steps: accept, a prime of the memory read, the walk over all N entries (one
// shared subtract/compare unit judges an entry a cycle and writes survivors
// back compacted), one more prime, then the emit pass over the survivors up to
// the last one resent, each resent entry sending its result. With nothing due,
// or with an empty queue, a single null result follows instead. All results carry final count.
// s_tready is high only in idle with the output register free or being taken;
// the emit pass holds its place at a resent entry until the output register is free.
// Reset (rst, synchronous) empties the queue, clears the ack and loads the
// register defaults; the entry memory itself is not cleared.
// Configuration over APB: 0x0 resend interval, 0x4 max attempts.
`default_nettype none
module reliable_retransmit_queue_unit
  import rrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // slave side
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [IN_TDATA_W-1:0]   s_tdata,   // [31:0] seq, [63:32] time_ms
  input  wire logic [OP_W-1:0]         s_tuser,   // [1:0] op
  // master side
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic [OUT_TDATA_W-1:0]       m_tdata,   // [31:0] resend_seq, [36:32] attempts_now,
                                                  // [41:37] pending_count, rest zero
  output logic [OUT_TUSER_W-1:0]       m_tuser,   // [0] resend, [1] overflow
  output logic                         m_tlast,
  // configuration
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_AW-1:0]       paddr,
  input  wire logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------- state
  state_t state, state_next;

  logic [CW-1:0]     count;
  logic [SEQ_W-1:0]  acked;
  logic [INT_W-1:0]  interval;
  logic [ATT_W-1:0]  max_att;
  logic [TIME_W-1:0] now_ms;

  logic [IW-1:0]     rd_idx;     // entry whose data sits in the read register
  logic [CW-1:0]     wr_cnt;     // survivors written back so far
  logic [IW-1:0]     e_idx;      // emit pass position
  logic [IW-1:0]     last_idx;   // last survivor marked as resent
  logic              any_rs;
  logic [QUEUE_DEPTH-1:0] flags; // resent marks, by compacted position

  // entry memory, one write and one registered read port
  logic [SEQ_W-1:0]  mem_seq  [QUEUE_DEPTH];
  logic [TIME_W-1:0] mem_time [QUEUE_DEPTH];
  logic [ATT_W-1:0]  mem_att  [QUEUE_DEPTH];
  logic [SEQ_W-1:0]  rd_seq;
  logic [TIME_W-1:0] rd_time;
  logic [ATT_W-1:0]  rd_att;

  // output register payload
  logic              o_resend, o_ovf, o_last;
  logic [SEQ_W-1:0]  o_seq;
  logic [ATT_W-1:0]  o_att;
  logic [PEND_W-1:0] o_pend;

  // ------------------------------------------------------- input decode
  logic              accept;
  logic              out_free;
  logic [SEQ_W-1:0]  in_seq;
  logic [TIME_W-1:0] in_time;
  logic              full;

  assign in_seq   = s_tdata[SEQ_W-1:0];
  assign in_time  = s_tdata[IN_TDATA_W-1:SEQ_W];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CW'(QUEUE_DEPTH));

  // ------------------------------------------- shared judge for one entry
  logic              walk_drop, walk_due, walk_keep, walk_end;
  logic [TIME_W-1:0] age;
  logic [ATT_W-1:0]  att_inc;

  assign age       = now_ms - rd_time;
  assign walk_drop = (rd_seq <= acked) || (rd_att >= max_att);
  assign walk_due  = age >= {{(TIME_W-INT_W){1'b0}}, interval};
  assign walk_keep = !walk_drop;
  assign att_inc   = rd_att + ATT_W'(1);
  assign walk_end  = (CW'(rd_idx) + CW'(1)) == count;

  logic emit_flag, emit_last;
  assign emit_flag = flags[e_idx];
  assign emit_last = (e_idx == last_idx);

  // ----------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && s_tuser == OP_TICK) begin
          state_next = (count == '0) ? ST_NULL : ST_WPRIME;
        end
      end
      ST_WPRIME: state_next = ST_WALK;
      ST_WALK: begin
        if (walk_end) begin
          state_next = (any_rs || (walk_keep && walk_due)) ? ST_EPRIME : ST_NULL;
        end
      end
      ST_EPRIME: state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_flag && out_free && emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_NULL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------ control outputs
  logic              load_out;
  logic              n_resend, n_ovf, n_last;
  logic [SEQ_W-1:0]  n_seq;
  logic [ATT_W-1:0]  n_att;
  logic [PEND_W-1:0] n_pend;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [SEQ_W-1:0]  w_seq;
  logic [TIME_W-1:0] w_time;
  logic [ATT_W-1:0]  w_att;
  logic              emit_adv;

  always_comb begin
    load_out  = 1'b0;
    n_resend  = 1'b0;
    n_ovf     = 1'b0;
    n_last    = 1'b1;
    n_seq     = '0;
    n_att     = '0;
    n_pend    = PEND_W'(count);
    mem_we    = 1'b0;
    mem_waddr = wr_cnt[IW-1:0];
    mem_raddr = '0;
    w_seq     = rd_seq;
    w_time    = walk_due ? now_ms : rd_time;
    w_att     = walk_due ? att_inc : rd_att;
    emit_adv  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_tuser)
            OP_ENQ: begin
              load_out = 1'b1;
              n_ovf    = full;
              n_pend   = full ? PEND_W'(count) : PEND_W'(count + CW'(1));
              mem_we    = !full;
              mem_waddr = count[IW-1:0];
              w_seq     = in_seq;
              w_time    = in_time;
              w_att     = '0;
            end
            OP_ACK:   load_out = 1'b1;
            OP_CLEAR: begin
              load_out = 1'b1;
              n_pend   = '0;
            end
            default: ;  // tick: results come after the walk, or as a null result on an empty queue
          endcase
        end
      end
      ST_WALK: begin
        mem_raddr = IW'(rd_idx + IW'(1));
        mem_we    = walk_keep;
      end
      ST_EMIT: begin
        emit_adv = !emit_flag || out_free;
        mem_raddr = emit_adv ? IW'(e_idx + IW'(1)) : e_idx;
        if (emit_flag && out_free) begin
          load_out = 1'b1;
          n_resend = 1'b1;
          n_seq    = rd_seq;
          n_att    = rd_att;
          n_last   = emit_last;
        end
      end
      ST_NULL: load_out = out_free;
      default: ;  // primes read address zero
    endcase
  end

  // -------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_seq[mem_waddr]  <= w_seq;
      mem_time[mem_waddr] <= w_time;
      mem_att[mem_waddr]  <= w_att;
    end
    rd_seq  <= mem_seq[mem_raddr];
    rd_time <= mem_time[mem_raddr];
    rd_att  <= mem_att[mem_raddr];
  end

  // ----------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      acked    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        case (s_tuser)
          OP_ENQ: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          OP_ACK: begin
            if (in_seq > acked) begin
              acked <= in_seq;
            end
          end
          OP_CLEAR: begin
            count <= '0;
            acked <= '0;
          end
          default: ;
        endcase
      end
      if (state == ST_WALK && walk_end) begin
        count <= wr_cnt + CW'(walk_keep);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= INTERVAL_RST;
      max_att  <= MAX_ATT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_INTERVAL: interval <= pwdata[INT_W-1:0];
        REG_MAX_ATT:  max_att  <= pwdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_INTERVAL: prdata = {{(APB_DW-INT_W){1'b0}}, interval};
      REG_MAX_ATT:  prdata = {{(APB_DW-ATT_W){1'b0}}, max_att};
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------- walk bookkeeping
  always_ff @(posedge clk) begin
    if (accept && s_tuser == OP_TICK) begin
      now_ms <= in_time;
      rd_idx <= '0;
      wr_cnt <= '0;
      e_idx  <= '0;
      any_rs <= 1'b0;
    end
    if (state == ST_WALK) begin
      rd_idx <= IW'(rd_idx + IW'(1));
      if (walk_keep) begin
        wr_cnt <= wr_cnt + CW'(1);
        flags[wr_cnt[IW-1:0]] <= walk_due;
        if (walk_due) begin
          any_rs   <= 1'b1;
          last_idx <= wr_cnt[IW-1:0];
        end
      end
    end
    if (state == ST_EMIT && emit_adv) begin
      e_idx <= IW'(e_idx + IW'(1));
    end
  end

  // ------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_resend <= n_resend;
      o_ovf    <= n_ovf;
      o_last   <= n_last;
      o_seq    <= n_seq;
      o_att    <= n_att;
      o_pend   <= n_pend;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-SEQ_W-ATT_W-PEND_W){1'b0}}, o_pend, o_att, o_seq};
  assign m_tuser = {o_ovf, o_resend};
  assign m_tlast = o_last;

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // compaction never writes ahead of the read position
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (wr_cnt <= CW'(rd_idx)))
    else $error("compaction write pointer ahead of read pointer");

  // single-result operations present their final result on the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != OP_TICK) |=> (m_tvalid && m_tlast))
    else $error("single-result operation gave no final result");

  // a resend result always carries a non-zero attempt count
  a_resend_att: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[SEQ_W+ATT_W-1:SEQ_W] != '0))
    else $error("resend result with bad attempt count");
`endif

endmodule
`default_nettype wire

[sim/reliable_retransmit_queue_unit_tb.sv]
// Self-checking testbench for the retransmission queue unit (enqueue, cumulative
// ack, tick with resends, clear, APB configuration). Needs rrq_pkg and
// reliable_retransmit_queue_unit; predicts every result from its own queue model.
`default_nettype none
module reliable_retransmit_queue_unit_tb;
  import rrq_pkg::*;

  localparam int QUEUE_DEPTH      = 16;
  localparam int QIW              = $clog2(QUEUE_DEPTH);
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SINK_HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES    = 6;     // block returns to idle after its final result

  // one result transaction as seen on the master side
  typedef struct packed {
    logic               resend;
    logic [SEQ_W-1:0]   seq;
    logic [ATT_W-1:0]   att;
    logic               overflow;
    logic [PEND_W-1:0]  pend;
    logic               last;
  } response_t;

  logic clk;
  logic rst = 1'b1;

  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] seq, [63:32] time_ms
  logic [OP_W-1:0]        s_tuser  = '0;   // [1:0] op
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] resend_seq, [36:32] attempts_now,
                                           // [41:37] pending_count, rest zero
  logic [OUT_TUSER_W-1:0] m_tuser;         // [0] resend, [1] overflow
  logic                   m_tlast;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [APB_DW-1:0]      pwdata  = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  // shared between the stimulus, the result sink and the checker
  response_t awaited_responses[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  bit        no_idle        = 1'b0;   // both sides run flat out while set
  bit        sink_hold_req  = 1'b0;   // asks the sink for one long hold-off

  // predictor state: queue contents, cumulative ack and register copies
  logic [SEQ_W-1:0]  held_seq  [QUEUE_DEPTH];
  logic [TIME_W-1:0] held_sent [QUEUE_DEPTH];
  logic [ATT_W-1:0]  held_att  [QUEUE_DEPTH];
  int                held_count = 0;
  logic [SEQ_W-1:0]  ack_mark   = '0;
  logic [INT_W-1:0]  ivl_ms     = INTERVAL_RST;
  logic [ATT_W-1:0]  att_limit  = MAX_ATT_RST;

  // traffic generator state for the random part
  logic [TIME_W-1:0] now_ms   = '0;
  logic [SEQ_W-1:0]  next_seq = '0;

  reliable_retransmit_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // Works out the results of one accepted input transaction and queues them.
  // Tick walks in order, drops acked or exhausted entries, resends the due
  // ones and compacts the survivors; every result carries the final count.
  function automatic void compute_responses(input logic [OP_W-1:0]   op,
                                            input logic [SEQ_W-1:0]  seq,
                                            input logic [TIME_W-1:0] now);
    response_t r;
    response_t batch[$];
    int        wr;
    logic [QIW-1:0] ri;
    logic [QIW-1:0] wi;
    logic [TIME_W-1:0] elapsed;
    r = '0;
    case (op)
      OP_ENQ: begin
        if (held_count < QUEUE_DEPTH) begin
          wi = QIW'(held_count);
          held_seq[wi]  = seq;
          held_sent[wi] = now;
          held_att[wi]  = '0;
          held_count++;
        end else begin
          r.overflow = 1'b1;
        end
        batch = {batch, r};
      end
      OP_ACK: begin
        if (seq > ack_mark) ack_mark = seq;
        batch = {batch, r};
      end
      OP_TICK: begin
        wr = 0;
        for (int rd = 0; rd < held_count; rd++) begin
          ri = QIW'(rd);
          wi = QIW'(wr);
          if (held_seq[ri] <= ack_mark || held_att[ri] >= att_limit) continue;
          elapsed = now - held_sent[ri];   // wraps modulo 2^32
          if (elapsed >= TIME_W'(ivl_ms)) begin
            held_sent[ri] = now;
            held_att[ri]  = held_att[ri] + ATT_W'(1);
            r          = '0;
            r.resend   = 1'b1;
            r.seq      = held_seq[ri];
            r.att      = held_att[ri];
            batch = {batch, r};
          end
          held_seq[wi]  = held_seq[ri];
          held_sent[wi] = held_sent[ri];
          held_att[wi]  = held_att[ri];
          wr++;
        end
        held_count = wr;
        if (batch.size() == 0) batch = {batch, r};
      end
      default: begin   // OP_CLEAR
        held_count = 0;
        ack_mark   = '0;
        batch = {batch, r};
      end
    endcase
    foreach (batch[i]) begin
      batch[i].pend = PEND_W'(held_count);
      batch[i].last = (i == batch.size() - 1);
      awaited_responses = {awaited_responses, batch[i]};
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Offers one input transaction. Valid stays high across back-to-back
  // transactions; it is lowered only when a gap precedes the next one or the sender waits for idle.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] seq,
                         input logic [TIME_W-1:0] now);
    int gap;
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom(), $urandom()};
      s_tuser  <= OP_W'($urandom());
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, seq};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    compute_responses(op, seq, now);
  endtask

  // sender stands still until every awaited result has been taken
  task automatic await_idle();
    s_tvalid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back over APB, only ever with the block idle.
  // Upper data bits carry noise; the registers keep only their own width.
  task automatic set_config(input logic [INT_W-1:0] ivl, input logic [ATT_W-1:0] lim);
    await_idle();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_INTERVAL, 2'b00};
    pwdata  <= {16'($urandom()), ivl};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    paddr   <= {REG_MAX_ATT, 2'b00};
    pwdata  <= {27'($urandom()), lim};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ivl_ms    = ivl;
    att_limit = lim;
  endtask

  // directed: extremes of seq and time, stale acks, wrap of the elapsed time,
  // an ack at the top of the range, clear
  task automatic test_basic_ops();
    send_op(OP_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // empty queue: lone null result
    send_op(OP_ENQ,   32'hFFFF_FFFF, 32'hFFFF_FFF0);  // stamped just before the wrap
    send_op(OP_ENQ,   32'h0,         32'h0);          // seq 0 never clears ack 0
    send_op(OP_ENQ,   32'd5,         32'h0);
    send_op(OP_ACK,   32'h0,         32'd10);         // not above the ack: ignored
    send_op(OP_TICK,  32'h0,         32'd100);        // 116 and 100 ms: nothing due
    send_op(OP_TICK,  32'h0,         32'd120);        // both survivors due
    send_op(OP_ACK,   32'd5,         32'd130);
    send_op(OP_ACK,   32'd3,         32'd131);        // stale
    send_op(OP_TICK,  32'h0,         32'd500);        // seq 5 acked away
    send_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(OP_ACK,   32'hFFFF_FFFF, 32'd600);
    send_op(OP_ENQ,   32'd7,         32'd600);
    send_op(OP_TICK,  32'h0,         32'd800);        // everything covered by the ack
    send_op(OP_CLEAR, 32'h0,         32'h0);
  endtask

  // zero interval, zero and one attempt limits, widest interval and limit
  task automatic test_config_extremes();
    logic [TIME_W-1:0] t;
    t = $urandom();
    set_config(16'd0, 5'd1);
    send_op(OP_ENQ,  32'd10, t);
    send_op(OP_ENQ,  32'd11, t);
    send_op(OP_TICK, 32'd0,  t);          // zero interval: both resent at once
    send_op(OP_TICK, 32'd0,  t);          // limit reached: both dropped
    set_config(16'hFFFF, 5'd0);
    send_op(OP_ENQ,  32'd20, t);
    send_op(OP_TICK, 32'd0,  t + 32'd70000);  // limit zero drops it untouched
    set_config(16'hFFFF, 5'd31);
    send_op(OP_ENQ,  32'd30, t);
    send_op(OP_TICK, 32'd0,  t + 32'd65534);  // one short of the interval
    send_op(OP_TICK, 32'd0,  t + 32'd65535);  // exactly due
  endtask

  // Receiver holds off while the sender keeps offering: the output register
  // fills and the input stalls. The queue is filled, overflows, and a tick
  // then produces the largest burst of resends.
  task automatic test_backpressure_fill();
    logic [TIME_W-1:0] t0;
    t0 = $urandom();
    set_config(16'd200, 5'd31);
    send_op(OP_CLEAR, 32'h0, t0);
    no_idle       = 1'b1;
    sink_hold_req = 1'b1;
    for (int i = 0; i <= QUEUE_DEPTH; i++) send_op(OP_ENQ, 32'h8000_0000 + i, t0 + i);
    no_idle = 1'b0;
    send_op(OP_TICK, $urandom(), t0 + 32'd216);   // every entry due
    send_op(OP_ENQ,  32'h1234,   t0 + 32'd300);   // still full after the tick
    await_idle();
  endtask

  // one random transaction: mostly well-formed traffic, some noise
  task automatic random_item();
    int pick;
    pick = $urandom_range(99, 0);
    if ($urandom_range(9, 0) == 0) now_ms += $urandom();
    else now_ms += $urandom_range(2 * int'(ivl_ms) + 2, 0);
    if (pick < 40) begin
      send_op(OP_ENQ, next_seq, now_ms);
      next_seq += $urandom_range(2, 1);
    end else if (pick < 70) begin
      send_op(OP_TICK, $urandom(), now_ms);
    end else if (pick < 85) begin
      send_op(OP_ACK, next_seq - $urandom_range(12, 0), now_ms);
    end else if (pick < 88) begin
      send_op(OP_CLEAR, $urandom(), $urandom());
    end else begin
      send_op(OP_W'($urandom()), $urandom(), $urandom());
    end
  endtask

  // random traffic over several register settings, one phase without idling
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_config(16'd0, 5'd31);
        1:       set_config(16'd1, 5'd3);
        2:       set_config(INT_W'($urandom_range(300, 2)), ATT_W'($urandom_range(30, 2)));
        3:       set_config(16'hFFFF, 5'd1);
        4:       set_config(INT_W'($urandom_range(65535, 1)), ATT_W'($urandom()));
        default: set_config(INTERVAL_RST, MAX_ATT_RST);
      endcase
      no_idle  = (phase == 2);
      now_ms   = $urandom();
      next_seq = $urandom();
      for (int n = 0; n < 26; n++) random_item();
      no_idle = 1'b0;
    end
  endtask

  // Result sink: random ready pattern, one long hold-off on request, and apart
  // from that hold-off always ready while no_idle is set.
  initial begin : result_sink
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        for (int c = 1; c < SINK_HOLD_CYCLES; c++) @(posedge clk);
        sink_hold_req = 1'b0;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(12, 1);
          stall_left = gap_len();
        end
      end
    end
  end

  // Checker: every result transaction against the oldest expectation.
  initial begin : result_check
    response_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (awaited_responses.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none awaited, expected nothing, actual tdata %0h tuser %0h",
                   $time, m_tdata, m_tuser);
        end else begin
          want = awaited_responses[0];
          awaited_responses.delete(0);
          check_field("resend",        32'(want.resend),   32'(m_tuser[0]));
          check_field("overflow",      32'(want.overflow), 32'(m_tuser[1]));
          check_field("resend_seq",    32'(want.seq),      32'(m_tdata[SEQ_W-1:0]));
          check_field("attempts_now",  32'(want.att),      32'(m_tdata[SEQ_W+ATT_W-1:SEQ_W]));
          check_field("pending_count", 32'(want.pend),
                      32'(m_tdata[SEQ_W+ATT_W+PEND_W-1:SEQ_W+ATT_W]));
          check_field("last",          32'(want.last),     32'(m_tlast));
        end
      end
    end
  end

  // watchdog: a hang or a lost result ends the run here
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results still awaited",
             $time, cycle_count, awaited_responses.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : run_tests
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_config_extremes();
    test_backpressure_fill();
    test_random_traffic();
    await_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
